// ----- src/ffsa_pkg.sv -----
// ----------------------------------------------------------------------------
// ffsa_pkg
// shared widths and status codes of the first-fit segment allocator
// ----------------------------------------------------------------------------
package ffsa_pkg;
  localparam int unsigned FreeEntries = 16;
  localparam int unsigned UsedEntries = 16;
  localparam int unsigned AddrBits    = 20;
  localparam int unsigned SizeBits    = AddrBits + 1;
  localparam int unsigned FreeIdxBits = $clog2(FreeEntries);
  localparam int unsigned UsedIdxBits = $clog2(UsedEntries);
  localparam int unsigned FreeCntBits = $clog2(FreeEntries + 1);
  localparam int unsigned UsedCntBits = $clog2(UsedEntries + 1);

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StNoFit   = 2'd1,
    StUnknown = 2'd2,
    StFull    = 2'd3
  } status_e;

  typedef enum logic {
    CmdAlloc   = 1'b0,
    CmdRelease = 1'b1
  } cmd_e;

  // one table entry: start offset and length
  typedef struct packed {
    logic [AddrBits-1:0] start;
    logic [SizeBits-1:0] len;
  } seg_t;
endpackage

// ----- src/first_fit_segment_allocator.sv -----
// ----------------------------------------------------------------------------
// first_fit_segment_allocator
// first-fit allocator with address-ordered free table and allocated table
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one request item: tdata = {release_address, request_size}
//   plus tuser = cmd (0 allocate, 1 release). m_axis returns one result item
//   per request: tdata = {block_address, status}.
//   pool_size is written through cfg_we_i / cfg_wdata_i while idle; a write
//   clears both tables to a single free segment [0, pool_size), or none if 0.
// timing:
//   the free and used tables sit in synchronous memories with one read and
//   one write port (registered read data). every table read is followed by
//   a bubble state. an item rejected up front goes straight to the output;
//   an allocate reads free entries in order, plus the shift for a used-up
//   segment; a release searches used entries, passes or moves free entries
//   and moves used entries down. one item at a time.
// reset:
//   rst_ni clears control; pool_size returns to 2^20 and the tables hold one
//   free segment. the entry 0 of the free table lives in the memory but a
//   fresh flag makes it read as (0, pool_size) until first written.
// stalls:
//   the result waits in the output register; the next item is taken while it
//   waits, but its own result must leave before the following one is made.
module first_fit_segment_allocator
  import ffsa_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [SizeBits-1:0] cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [20:0] request_size, [40:21] release_address, [47:41] zero
  input  logic [47:0]         s_axis_tdata,
  // [0] cmd
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [1:0] status, [21:2] block_address, [23:22] zero
  output logic [23:0]         m_axis_tdata
);

  typedef enum logic [10:0] {
    SIdle    = 11'b00000000001,
    SAScan   = 11'b00000000010, // alloc: read free entries in order
    SAUpd    = 11'b00000000100, // alloc: write shrunk segment or start drop
    SFShift  = 11'b00000001000, // shift free entries (down or up)
    SRScan   = 11'b00000010000, // release: search used table newest first
    SRLen    = 11'b00000100000, // release: decide after match
    SRPos    = 11'b00001000000, // release: find insert point in free table
    SRIns    = 11'b00010000000, // release: write new free entry
    SUShift  = 11'b00100000000, // remove used entry by shifting down
    SOut     = 11'b01000000000, // hand result to the output register
    SWait    = 11'b10000000000  // sync read latency bubble
  } state_e;

  state_e state_q, state_d, ret_q, ret_d;

  // memories
  seg_t free_mem [FreeEntries];
  seg_t used_mem [UsedEntries];
  seg_t free_rd_q, used_rd_q;

  logic                   free_we, used_we;
  logic [FreeIdxBits-1:0] free_waddr, free_raddr;
  logic [UsedIdxBits-1:0] used_waddr, used_raddr;
  seg_t                   free_wdata, used_wdata;
  logic                   free_re, used_re;

  always_ff @(posedge clk_i) begin
    if (free_we) free_mem[free_waddr] <= free_wdata;
    if (free_re) free_rd_q <= free_mem[free_raddr];
    if (used_we) used_mem[used_waddr] <= used_wdata;
    if (used_re) used_rd_q <= used_mem[used_raddr];
  end

  // registers
  logic [SizeBits-1:0]    pool_q;
  logic                   fresh_q, fresh_d;   // free entry 0 still (0,pool)
  logic                   frd_slot0_q;        // last free read was entry 0
  logic [FreeCntBits-1:0] fcnt_q, fcnt_d;
  logic [UsedCntBits-1:0] ucnt_q, ucnt_d;
  logic [FreeCntBits-1:0] fi_q, fi_d, fend_q, fend_d;
  logic [UsedCntBits-1:0] ui_q, ui_d;
  logic                   fdir_q, fdir_d;     // 0 shift down, 1 shift up
  logic                   cmd_q;
  logic [SizeBits-1:0]    want_q;
  logic [AddrBits-1:0]    rel_q;
  seg_t                   hold_q, hold_d;
  logic [1:0]             st_q, st_d;
  logic [AddrBits-1:0]    addr_q, addr_d;
  logic                   ovalid_q, ovalid_d;
  logic [1:0]             ost_q, ost_d;
  logic [AddrBits-1:0]    oaddr_q, oaddr_d;

  logic [SizeBits-1:0] pool_clamp;
  assign pool_clamp = (cfg_wdata_i > SizeBits'(1 << AddrBits))
                      ? SizeBits'(1 << AddrBits) : cfg_wdata_i;

  seg_t free_rd;
  assign free_rd = (fresh_q && frd_slot0_q) ? seg_t'{start: '0, len: pool_q} : free_rd_q;

  assign s_axis_tready = (state_q == SIdle) && !cfg_we_i;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {2'b00, oaddr_q, ost_q};

  // insert slot: after an upward shift it is fend, else fi
  function automatic logic [FreeCntBits-1:0] fend_sel(
    input logic dir, input logic [FreeCntBits-1:0] fi, input logic [FreeCntBits-1:0] fe);
    return dir ? fe : fi;
  endfunction

  always_comb begin
    state_d = state_q; ret_d = ret_q;
    fresh_d = fresh_q; fcnt_d = fcnt_q; ucnt_d = ucnt_q;
    fi_d = fi_q; fend_d = fend_q; ui_d = ui_q; fdir_d = fdir_q;
    hold_d = hold_q; st_d = st_q; addr_d = addr_q;
    ovalid_d = ovalid_q; ost_d = ost_q; oaddr_d = oaddr_q;
    free_we = 1'b0; free_waddr = '0; free_wdata = '0;
    free_re = 1'b0; free_raddr = '0;
    used_we = 1'b0; used_waddr = '0; used_wdata = '0;
    used_re = 1'b0; used_raddr = '0;

    if (ovalid_q && m_axis_tready) ovalid_d = 1'b0;

    unique case (state_q)
      SIdle: begin
        if (s_axis_tvalid && s_axis_tready) begin
          st_d   = StOk;
          addr_d = '0;
          fdir_d = 1'b0;
          if (s_axis_tuser == CmdAlloc) begin
            if (ucnt_q >= UsedCntBits'(UsedEntries)) begin
              st_d = StFull; state_d = SOut;
            end else if (fcnt_q == '0) begin
              st_d = StNoFit; state_d = SOut;
            end else begin
              free_re = 1'b1; free_raddr = '0;
              fi_d = '0; state_d = SWait; ret_d = SAScan;
            end
          end else begin
            if (ucnt_q == '0) begin
              st_d = StUnknown; state_d = SOut;
            end else begin
              ui_d = ucnt_q - 1'b1;
              used_re = 1'b1; used_raddr = UsedIdxBits'(ucnt_q - 1'b1);
              state_d = SWait; ret_d = SRScan;
            end
          end
        end
      end
      SWait: state_d = ret_q;
      SAScan: begin
        if (free_rd.len >= want_q) begin
          addr_d = free_rd.start;
          used_we = 1'b1; used_waddr = UsedIdxBits'(ucnt_q);
          used_wdata = '{start: free_rd.start, len: want_q};
          ucnt_d = ucnt_q + 1'b1;
          hold_d = '{start: free_rd.start + want_q[AddrBits-1:0],
                     len: free_rd.len - want_q};
          state_d = SAUpd;
        end else if (fi_q + 1'b1 >= fcnt_q) begin
          st_d = StNoFit; state_d = SOut;
        end else begin
          fi_d = fi_q + 1'b1;
          free_re = 1'b1; free_raddr = FreeIdxBits'(fi_q + 1'b1);
          state_d = SWait; ret_d = SAScan;
        end
      end
      SAUpd: begin
        if (fi_q == '0) fresh_d = 1'b0;
        if (hold_q.len != '0) begin
          free_we = 1'b1; free_waddr = FreeIdxBits'(fi_q); free_wdata = hold_q;
          state_d = SOut;
        end else begin
          // drop entry fi by moving later entries down one
          fcnt_d = fcnt_q - 1'b1; fdir_d = 1'b0;
          fend_d = fcnt_q - 1'b1; ret_d = SOut;
          if (fi_q + 1'b1 >= fcnt_q) state_d = SOut;
          else begin
            free_re = 1'b1; free_raddr = FreeIdxBits'(fi_q + 1'b1);
            state_d = SWait; ret_d = SFShift;
          end
        end
      end
      SFShift: begin
        // down: data just read from fi+1 goes to fi; up: from fi-1 to fi
        free_we = 1'b1; free_waddr = FreeIdxBits'(fi_q); free_wdata = free_rd;
        if (fi_q == '0) fresh_d = 1'b0;
        if (fdir_q == 1'b0) begin
          if (fi_q + 2'd2 > fend_q) state_d = SOut;
          else begin
            fi_d = fi_q + 1'b1;
            free_re = 1'b1; free_raddr = FreeIdxBits'(fi_q + 2'd2);
            state_d = SWait; ret_d = SFShift;
          end
        end else begin
          if (fi_q - 1'b1 <= fend_q) state_d = SRIns;
          else begin
            fi_d = fi_q - 1'b1;
            free_re = 1'b1; free_raddr = FreeIdxBits'(fi_q - 2'd2);
            state_d = SWait; ret_d = SFShift;
          end
        end
      end
      SRScan: begin
        if (used_rd_q.start == rel_q) begin
          hold_d = used_rd_q; state_d = SRLen;
        end else if (ui_q == '0) begin
          st_d = StUnknown; state_d = SOut;
        end else begin
          ui_d = ui_q - 1'b1;
          used_re = 1'b1; used_raddr = UsedIdxBits'(ui_q - 1'b1);
          state_d = SWait; ret_d = SRScan;
        end
      end
      SRLen: begin
        if (hold_q.len == '0) begin
          state_d = SUShift; ret_d = SOut;
          ucnt_d = ucnt_q - 1'b1;
          if (ui_q + 1'b1 < ucnt_q) begin
            used_re = 1'b1; used_raddr = UsedIdxBits'(ui_q + 1'b1);
            state_d = SWait; ret_d = SUShift;
          end else state_d = SOut;
        end else if (fcnt_q >= FreeCntBits'(FreeEntries)) begin
          st_d = StFull; state_d = SOut;
        end else if (fcnt_q == '0) begin
          fi_d = '0; state_d = SRIns;
        end else begin
          fi_d = '0; free_re = 1'b1; free_raddr = '0;
          state_d = SWait; ret_d = SRPos;
        end
      end
      SRPos: begin
        if (free_rd.start > rel_q) begin
          // make room at fi by moving [fi, fcnt) up one
          fend_d = fi_q; fdir_d = 1'b1; fi_d = fcnt_q;
          free_re = 1'b1; free_raddr = FreeIdxBits'(fcnt_q - 1'b1);
          state_d = SWait; ret_d = SFShift;
        end else if (fi_q + 1'b1 >= fcnt_q) begin
          fi_d = fcnt_q; state_d = SRIns;
        end else begin
          fi_d = fi_q + 1'b1;
          free_re = 1'b1; free_raddr = FreeIdxBits'(fi_q + 1'b1);
          state_d = SWait; ret_d = SRPos;
        end
      end
      SRIns: begin
        free_we = 1'b1; free_waddr = FreeIdxBits'(fend_sel(fdir_q, fi_q, fend_q));
        free_wdata = hold_q;
        if (fend_sel(fdir_q, fi_q, fend_q) == '0) fresh_d = 1'b0;
        fcnt_d = fcnt_q + 1'b1;
        ucnt_d = ucnt_q - 1'b1;
        if (ui_q + 1'b1 < ucnt_q) begin
          used_re = 1'b1; used_raddr = UsedIdxBits'(ui_q + 1'b1);
          state_d = SWait; ret_d = SUShift;
        end else state_d = SOut;
      end
      SUShift: begin
        used_we = 1'b1; used_waddr = UsedIdxBits'(ui_q); used_wdata = used_rd_q;
        if (ui_q + 2'd2 > ucnt_q) state_d = SOut;
        else begin
          ui_d = ui_q + 1'b1;
          used_re = 1'b1; used_raddr = UsedIdxBits'(ui_q + 2'd2);
          state_d = SWait; ret_d = SUShift;
        end
      end
      SOut: begin
        if (!ovalid_q || m_axis_tready) begin
          ovalid_d = 1'b1; ost_d = st_q;
          oaddr_d = (st_q == StOk && cmd_q == CmdAlloc) ? addr_q : '0;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase

    // pool write: tables collapse to one free segment, or none for a zero pool
    if (cfg_we_i) begin
      fresh_d = 1'b1;
      fcnt_d  = (pool_clamp == '0) ? '0 : FreeCntBits'(1);
      ucnt_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      ret_q    <= SIdle;
      pool_q   <= SizeBits'(1 << AddrBits);
      fresh_q  <= 1'b1;
      fcnt_q   <= FreeCntBits'(1);
      ucnt_q   <= '0;
      ovalid_q <= 1'b0;
      fdir_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      ret_q    <= ret_d;
      fresh_q  <= fresh_d;
      fcnt_q   <= fcnt_d;
      ucnt_q   <= ucnt_d;
      ovalid_q <= ovalid_d;
      fdir_q   <= fdir_d;
      if (cfg_we_i) pool_q <= pool_clamp;
    end
  end

  always_ff @(posedge clk_i) begin
    fi_q   <= fi_d;
    fend_q <= fend_d;
    ui_q   <= ui_d;
    hold_q <= hold_d;
    st_q   <= st_d;
    addr_q <= addr_d;
    ost_q  <= ost_d;
    oaddr_q <= oaddr_d;
    if (free_re) frd_slot0_q <= (free_raddr == '0);
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_q  <= s_axis_tuser;
      want_q <= s_axis_tdata[SizeBits-1:0];
      rel_q  <= s_axis_tdata[SizeBits+AddrBits-1:SizeBits];
    end
  end

endmodule
